FILE: rtl/core/vtpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the vertex transform and perspective divide core.
// Used by every module under rtl/core; depends on nothing.
package vtpd_pkg;

    localparam int DEFAULT_FRAC_BITS = 16;

    localparam int COORD_W   = 32;
    localparam int CFG_DATA_W = 64;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = 6;
    localparam int NUM_LANES = 3;
    localparam int NUM_COLS  = 4;
    localparam int PROD_W    = 64;
    localparam int SUM_W     = 66;
    localparam int DIV_W     = 64;

    localparam logic [REG_IDX_W-1:0] REG_ROW0_C01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_C23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_C01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_C23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_C01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_C23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_C01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_C23 = 3'd7;

    localparam logic [COORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] SAT_NEG = 32'h8000_0000;

    typedef logic [NUM_REGS-1:0][CFG_DATA_W-1:0] vtpd_matrix_t;

    // Control bits that travel down the divider beside the data words.
    typedef struct packed {
        logic                 valid;
        logic                 wzero;
        logic [NUM_LANES-1:0] neg;
    } vtpd_tag_t;

endpackage

FILE: rtl/core/vertex_transform_perspective_divide_core.sv
`timescale 1ns / 1ps
// Top level of the vertex transform and perspective divide core.
// Depends on vtpd_pkg, vtpd_cfg, vtpd_xform and vtpd_div_step.
//
// Usage:
//   A vertex word (x_in, y_in, z_in, signed fixed point) is taken at each
//   rising edge where start is high and busy is low. busy is never raised,
//   so one vertex can be taken every clock.
//   The result word (x_out, y_out, z_out, w_was_zero, saturated) is shown
//   for one cycle with done high. Results leave in the order vertices
//   came in. The receiver cannot hold results off and there is no stall.
//   Pipeline: the input register loads at the edge that takes the vertex,
//   then 32x32 products, two adder levels and rescale, 64 one-bit division
//   steps, and an output register.
//   Throughput: one vertex per clock, set by the fully pipelined divider.
//   The matrix sits in eight 64-bit APB registers at byte addresses 8*i;
//   write it only while no vertex is in flight. Reset loads the identity
//   matrix and empties the pipeline; nothing is emitted until new input.
module vertex_transform_perspective_divide_core #(
    parameter int FRAC_BITS = vtpd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [vtpd_pkg::ADDR_W-1:0]             paddr,
    input  logic [vtpd_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [vtpd_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                    pready,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [vtpd_pkg::COORD_W-1:0]     x_in,
    input  logic signed [vtpd_pkg::COORD_W-1:0]     y_in,
    input  logic signed [vtpd_pkg::COORD_W-1:0]     z_in,
    output logic                                    done,
    output logic signed [vtpd_pkg::COORD_W-1:0]     x_out,
    output logic signed [vtpd_pkg::COORD_W-1:0]     y_out,
    output logic signed [vtpd_pkg::COORD_W-1:0]     z_out,
    output logic                                    w_was_zero,
    output logic                                    saturated
);
    import vtpd_pkg::*;

    vtpd_matrix_t                     matrix;
    vtpd_tag_t                        tag [DIV_W+1];
    logic [NUM_LANES-1:0][DIV_W-1:0]  dq [DIV_W+1];
    logic [NUM_LANES-1:0][DIV_W-1:0]  rem [DIV_W+1];
    logic [DIV_W-1:0]                 dvs [DIV_W+1];

    logic [NUM_LANES-1:0][COORD_W-1:0] res;
    logic [NUM_LANES-1:0]              sat;
    logic                              neg;
    logic                              big_pos, big_neg;

    logic                              done_reg;
    logic [NUM_LANES-1:0][COORD_W-1:0] res_reg;
    logic                              wzero_reg, sat_reg;

    vtpd_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .matrix  (matrix)
    );

    vtpd_xform #(
        .FRAC_BITS (FRAC_BITS)
    ) u_xform (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start && !busy),
        .x_in     (x_in),
        .y_in     (y_in),
        .z_in     (z_in),
        .matrix   (matrix),
        .tag      (tag[0]),
        .dividend (dq[0]),
        .divisor  (dvs[0])
    );

    assign rem[0] = '0;

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_div
        vtpd_div_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .tag_in  (tag[i]),
            .dq_in   (dq[i]),
            .rem_in  (rem[i]),
            .dvs_in  (dvs[i]),
            .tag_out (tag[i+1]),
            .dq_out  (dq[i+1]),
            .rem_out (rem[i+1]),
            .dvs_out (dvs[i+1])
        );
    end

    // A quotient of zero is never negative; negative values may reach -2^31.
    always_comb
    begin
        neg     = 1'b0;
        big_pos = 1'b0;
        big_neg = 1'b0;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            neg     = tag[DIV_W].neg[k] && (dq[DIV_W][k] != '0);
            big_pos = dq[DIV_W][k] > DIV_W'(SAT_POS);
            big_neg = dq[DIV_W][k] > DIV_W'(SAT_NEG);
            if (neg)
            begin
                sat[k] = big_neg;
                res[k] = big_neg ? SAT_NEG : COORD_W'(-dq[DIV_W][k][COORD_W-1:0]);
            end
            else
            begin
                sat[k] = big_pos;
                res[k] = big_pos ? SAT_POS : dq[DIV_W][k][COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= tag[DIV_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg   <= res;
        wzero_reg <= tag[DIV_W].wzero;
        sat_reg   <= |sat;
    end

    assign busy       = 1'b0;
    assign done       = done_reg;
    assign x_out      = res_reg[0];
    assign y_out      = res_reg[1];
    assign z_out      = res_reg[2];
    assign w_was_zero = wzero_reg;
    assign saturated  = sat_reg;

endmodule

FILE: rtl/core/vtpd_cfg.sv
`timescale 1ns / 1ps
// APB register file holding the 4x4 matrix, two entries per 64-bit register.
// Depends on vtpd_pkg.
module vtpd_cfg #(
    parameter int FRAC_BITS = vtpd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [vtpd_pkg::ADDR_W-1:0]        paddr,
    input  logic [vtpd_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [vtpd_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                               pready,
    output vtpd_pkg::vtpd_matrix_t             matrix
);
    import vtpd_pkg::*;

    localparam logic [CFG_DATA_W-1:0] ONE = CFG_DATA_W'(1) << FRAC_BITS;

    // Identity matrix, highest register first.
    localparam vtpd_matrix_t RESET_MATRIX = {
        ONE << 32, {CFG_DATA_W{1'b0}}, ONE, {CFG_DATA_W{1'b0}},
        {CFG_DATA_W{1'b0}}, ONE << 32, {CFG_DATA_W{1'b0}}, ONE
    };

    vtpd_matrix_t         regs_reg;
    logic [REG_IDX_W-1:0] idx;

    assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
    assign pready = 1'b1;
    assign prdata = regs_reg[idx];
    assign matrix = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= RESET_MATRIX;
        end
        else if (psel && penable && pwrite && pready)
        begin
            regs_reg[idx] <= pwdata;
        end
    end

endmodule

FILE: rtl/core/vtpd_xform.sv
`timescale 1ns / 1ps
// Matrix multiply pipeline: input register, products, two adder levels, and
// rescale with sign split that feeds the divider. Depends on vtpd_pkg.
module vtpd_xform #(
    parameter int FRAC_BITS = vtpd_pkg::DEFAULT_FRAC_BITS
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   start,
    input  logic signed [vtpd_pkg::COORD_W-1:0]                    x_in,
    input  logic signed [vtpd_pkg::COORD_W-1:0]                    y_in,
    input  logic signed [vtpd_pkg::COORD_W-1:0]                    z_in,
    input  vtpd_pkg::vtpd_matrix_t                                 matrix,
    output vtpd_pkg::vtpd_tag_t                                    tag,
    output logic [vtpd_pkg::NUM_LANES-1:0][vtpd_pkg::DIV_W-1:0]    dividend,
    output logic [vtpd_pkg::DIV_W-1:0]                             divisor
);
    import vtpd_pkg::*;

    logic                              v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [COORD_W-1:0]         vec_reg [NUM_LANES];
    logic signed [PROD_W-1:0]          prod_reg [NUM_COLS][NUM_LANES];
    logic signed [SUM_W-1:0]           trans_reg [NUM_COLS];
    logic signed [SUM_W-1:0]           pa_reg [NUM_COLS];
    logic signed [SUM_W-1:0]           pb_reg [NUM_COLS];
    logic signed [SUM_W-1:0]           sum_reg [NUM_COLS];
    logic signed [SUM_W-1:0]           scaled [NUM_COLS];
    logic [SUM_W-1:0]                  mag [NUM_COLS];
    logic [SUM_W-1:0]                  shifted [NUM_LANES];
    logic                              wzero;
    vtpd_tag_t                         tag_reg;
    logic [NUM_LANES-1:0][DIV_W-1:0]   dividend_reg;
    logic [DIV_W-1:0]                  divisor_reg;

    function automatic logic signed [COORD_W-1:0] entry(
        input vtpd_matrix_t m,
        input int           r,
        input int           c
    );
        logic [CFG_DATA_W-1:0] w;
        w = m[r * 2 + c / 2];
        return (c % 2 == 1) ? w[CFG_DATA_W-1:COORD_W] : w[COORD_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            tag_reg <= '0;
        end
        else
        begin
            v1_reg        <= start;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            tag_reg.valid <= v4_reg;
            tag_reg.wzero <= wzero;
            // The quotient is negative when the lane and w differ in sign.
            for (int k = 0; k < NUM_LANES; k++)
            begin
                tag_reg.neg[k] <= (scaled[k] < 0) != (scaled[3] < 0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg[0] <= x_in;
        vec_reg[1] <= y_in;
        vec_reg[2] <= z_in;
        for (int c = 0; c < NUM_COLS; c++)
        begin
            for (int r = 0; r < NUM_LANES; r++)
            begin
                prod_reg[c][r] <= PROD_W'(vec_reg[r]) * PROD_W'(entry(matrix, r, c));
            end
            trans_reg[c] <= SUM_W'(entry(matrix, 3, c)) <<< FRAC_BITS;
            pa_reg[c]    <= SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1]);
            pb_reg[c]    <= SUM_W'(prod_reg[c][2]) + trans_reg[c];
            sum_reg[c]   <= pa_reg[c] + pb_reg[c];
        end
        for (int k = 0; k < NUM_LANES; k++)
        begin
            dividend_reg[k] <= wzero ? mag[k][DIV_W-1:0] : shifted[k][DIV_W-1:0];
        end
        divisor_reg <= wzero ? DIV_W'(1) : mag[3][DIV_W-1:0];
    end

    // The arithmetic shift rounds toward minus infinity. With w zero the
    // divider is given a divisor of one so the sums pass through unchanged.
    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            scaled[c] = sum_reg[c] >>> FRAC_BITS;
            mag[c]    = (scaled[c] < 0) ? SUM_W'(-scaled[c]) : SUM_W'(scaled[c]);
        end
        for (int k = 0; k < NUM_LANES; k++)
        begin
            shifted[k] = mag[k] << FRAC_BITS;
        end
        wzero = (scaled[3] == '0);
    end

    assign tag      = tag_reg;
    assign dividend = dividend_reg;
    assign divisor  = divisor_reg;

endmodule

FILE: rtl/core/vtpd_div_step.sv
`timescale 1ns / 1ps
// One registered restoring-division step, one quotient bit for each of the
// three lanes against a shared divisor. Depends on vtpd_pkg.
module vtpd_div_step (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  vtpd_pkg::vtpd_tag_t                                    tag_in,
    input  logic [vtpd_pkg::NUM_LANES-1:0][vtpd_pkg::DIV_W-1:0]    dq_in,
    input  logic [vtpd_pkg::NUM_LANES-1:0][vtpd_pkg::DIV_W-1:0]    rem_in,
    input  logic [vtpd_pkg::DIV_W-1:0]                             dvs_in,
    output vtpd_pkg::vtpd_tag_t                                    tag_out,
    output logic [vtpd_pkg::NUM_LANES-1:0][vtpd_pkg::DIV_W-1:0]    dq_out,
    output logic [vtpd_pkg::NUM_LANES-1:0][vtpd_pkg::DIV_W-1:0]    rem_out,
    output logic [vtpd_pkg::DIV_W-1:0]                             dvs_out
);
    import vtpd_pkg::*;

    vtpd_tag_t                        tag_reg;
    logic [NUM_LANES-1:0][DIV_W-1:0]  dq_reg, rem_reg;
    logic [DIV_W-1:0]                 dvs_reg;
    logic [DIV_W:0]                   trial [NUM_LANES];
    logic [DIV_W:0]                   diff [NUM_LANES];
    logic [NUM_LANES-1:0]             fits;

    // The dividend shifts out of the top of dq while quotient bits enter below.
    always_comb
    begin
        for (int k = 0; k < NUM_LANES; k++)
        begin
            trial[k] = {rem_in[k], dq_in[k][DIV_W-1]};
            diff[k]  = trial[k] - {1'b0, dvs_in};
            fits[k]  = trial[k] >= {1'b0, dvs_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_in;
        for (int k = 0; k < NUM_LANES; k++)
        begin
            dq_reg[k]  <= {dq_in[k][DIV_W-2:0], fits[k]};
            rem_reg[k] <= fits[k] ? diff[k][DIV_W-1:0] : trial[k][DIV_W-1:0];
        end
    end

    assign tag_out = tag_reg;
    assign dq_out  = dq_reg;
    assign rem_out = rem_reg;
    assign dvs_out = dvs_reg;

endmodule
